// File: rtl/hed_pkg.sv
// ============================================================================
// hed_pkg
// Shared types, constants and helper functions for the HTML character
// reference decoder.
// ============================================================================
package hed_pkg;

    localparam int MAX_REF_CHARS_DEF = 15;

    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_LOW_X = 8'h78;  // 'x'
    localparam logic [7:0] CH_UP_X  = 8'h58;  // 'X'
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [20:0] CP_LIMIT = 21'h110000;
    localparam logic [25:0] ACC_MAX  = 26'h1FFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHARS,
        S_TAIL,
        S_UTF
    } t_state;

    // Source of the byte loaded into the output register.
    typedef enum logic [2:0] {
        SRC_IN,
        SRC_NAMED,
        SRC_UTF,
        SRC_AMP,
        SRC_CHAR,
        SRC_TAIL
    } t_src;

    // Update of the reference collector at an accepted transaction.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_START,
        ACT_STORE,
        ACT_STORE_END,
        ACT_END
    } t_act;

    typedef struct packed {
        logic accept;
        t_act act;
        logic load;
        t_src src;
        logic run_end;
        logic text_end;
    } t_cmd;

    typedef struct packed {
        logic       collecting;
        logic       is_amp;
        logic       is_semi;
        logic       full;
        logic       named_ok;
        logic       num_ok;
        logic [2:0] ulen;
        logic       out_free;
    } t_stat;

    // Returns {valid, value} for one digit character.
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
        logic [4:0] d;
        d = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b1, 4'(c - 8'h30)};
        end else if (hex && c >= 8'h61 && c <= 8'h66) begin
            d = {1'b1, 4'(c - 8'h57)};
        end else if (hex && c >= 8'h41 && c <= 8'h46) begin
            d = {1'b1, 4'(c - 8'h37)};
        end
        return d;
    endfunction

    // One byte of the UTF-8 encoding of cp, which is ulen bytes long.
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] ulen,
                                             input logic [1:0] idx);
        logic [7:0] b;
        b = cp[7:0];
        case (ulen)
            3'd2: begin
                b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            3'd3: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = cp[7:0];
        endcase
        return b;
    endfunction

endpackage

// File: rtl/hed_dp.sv
// ============================================================================
// hed_dp
// Datapath: reference byte buffer, numeric accumulator, name matching,
// UTF-8 encoding and the output register.
// ============================================================================
module hed_dp #(
    parameter int MAX_REF_CHARS = hed_pkg::MAX_REF_CHARS_DEF,
    localparam int CW = $clog2(MAX_REF_CHARS + 1),
    localparam int IW = $clog2(MAX_REF_CHARS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_byte,
    input  hed_pkg::t_cmd  i_cmd,
    input  logic [CW-1:0]  i_idx,
    input  logic           i_out_ready,
    output hed_pkg::t_stat o_stat,
    output logic [CW-1:0]  o_count,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_run_end,
    output logic           o_text_end
);

    logic          r_coll;
    logic [CW-1:0] r_count;
    logic [7:0]    r_chars [MAX_REF_CHARS];
    logic [7:0]    r_tail;
    logic          r_num_ok;
    logic          r_hex;
    logic [20:0]   r_acc;
    logic          r_ovf;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_run_end;
    logic          r_text_end;

    logic [4:0]  dig;
    logic [24:0] acc_mul;
    logic [25:0] acc_sum;
    logic        acc_sat;
    logic        named_ok;
    logic [7:0]  named_byte;
    logic [2:0]  ulen;
    logic        num_ok;
    logic [7:0]  sel_byte;
    logic        store;

    assign store = (i_cmd.act == hed_pkg::ACT_STORE) || (i_cmd.act == hed_pkg::ACT_STORE_END);

    // Saturating accumulate of the incoming digit.
    assign dig     = hed_pkg::digit_of(i_byte, r_hex);
    assign acc_mul = r_hex ? {r_acc, 4'b0000} : ({4'b0000, r_acc} << 3) + ({4'b0000, r_acc} << 1);
    assign acc_sum = {1'b0, acc_mul} + {22'd0, dig[3:0]};
    assign acc_sat = acc_sum > hed_pkg::ACC_MAX;

    always_comb begin
        named_ok   = 1'b0;
        named_byte = hed_pkg::CH_AMP;
        if (r_count == CW'(3) && r_chars[0] == 8'h61 && r_chars[1] == 8'h6D
                && r_chars[2] == 8'h70) begin
            named_ok   = 1'b1;
            named_byte = hed_pkg::CH_AMP;
        end else if (r_count == CW'(2) && r_chars[0] == 8'h6C && r_chars[1] == 8'h74) begin
            named_ok   = 1'b1;
            named_byte = hed_pkg::CH_LT;
        end else if (r_count == CW'(2) && r_chars[0] == 8'h67 && r_chars[1] == 8'h74) begin
            named_ok   = 1'b1;
            named_byte = hed_pkg::CH_GT;
        end else if (r_count == CW'(4) && r_chars[0] == 8'h71 && r_chars[1] == 8'h75
                && r_chars[2] == 8'h6F && r_chars[3] == 8'h74) begin
            named_ok   = 1'b1;
            named_byte = hed_pkg::CH_QUOT;
        end else if (r_count == CW'(4) && r_chars[0] == 8'h61 && r_chars[1] == 8'h70
                && r_chars[2] == 8'h6F && r_chars[3] == 8'h73) begin
            named_ok   = 1'b1;
            named_byte = hed_pkg::CH_APOS;
        end else if (r_count == CW'(4) && r_chars[0] == 8'h6E && r_chars[1] == 8'h62
                && r_chars[2] == 8'h73 && r_chars[3] == 8'h70) begin
            named_ok   = 1'b1;
            named_byte = hed_pkg::CH_SPACE;
        end
    end

    // A bare "#x" has no digits and therefore fails.
    assign num_ok = r_num_ok && (r_count >= CW'(2)) && !(r_hex && r_count == CW'(2))
                    && !r_ovf && (r_acc != 21'd0) && (r_acc < hed_pkg::CP_LIMIT);

    always_comb begin
        if (r_acc < 21'h80) begin
            ulen = 3'd1;
        end else if (r_acc < 21'h800) begin
            ulen = 3'd2;
        end else if (r_acc < 21'h10000) begin
            ulen = 3'd3;
        end else begin
            ulen = 3'd4;
        end
    end

    always_comb begin
        o_stat.collecting = r_coll;
        o_stat.is_amp     = (i_byte == hed_pkg::CH_AMP);
        o_stat.is_semi    = (i_byte == hed_pkg::CH_SEMI);
        o_stat.full       = (r_count == CW'(MAX_REF_CHARS));
        o_stat.named_ok   = named_ok;
        o_stat.num_ok     = num_ok;
        o_stat.ulen       = ulen;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        case (i_cmd.src)
            hed_pkg::SRC_IN:    sel_byte = i_byte;
            hed_pkg::SRC_NAMED: sel_byte = named_byte;
            hed_pkg::SRC_UTF:   sel_byte = hed_pkg::utf8_byte(r_acc, ulen, i_idx[1:0]);
            hed_pkg::SRC_AMP:   sel_byte = hed_pkg::CH_AMP;
            hed_pkg::SRC_CHAR:  sel_byte = r_chars[i_idx[IW-1:0]];
            hed_pkg::SRC_TAIL:  sel_byte = r_tail;
            default:            sel_byte = i_byte;
        endcase
    end

    // Collector control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll  <= 1'b0;
            r_count <= '0;
        end else begin
            case (i_cmd.act)
                hed_pkg::ACT_START: begin
                    r_coll  <= 1'b1;
                    r_count <= '0;
                end
                hed_pkg::ACT_STORE: begin
                    r_count <= r_count + CW'(1);
                end
                hed_pkg::ACT_STORE_END, hed_pkg::ACT_END: begin
                    r_coll  <= 1'b0;
                    r_count <= '0;
                end
                default: ;
            endcase
        end
    end

    // Buffered bytes and the running numeric parse.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tail <= i_byte;
        end
        if (store) begin
            r_chars[r_count[IW-1:0]] <= i_byte;
            if (r_count == '0) begin
                r_num_ok <= (i_byte == hed_pkg::CH_HASH);
                r_hex    <= 1'b0;
                r_acc    <= '0;
                r_ovf    <= 1'b0;
            end else if (r_count == CW'(1)
                    && (i_byte == hed_pkg::CH_LOW_X || i_byte == hed_pkg::CH_UP_X)) begin
                r_hex <= 1'b1;
            end else if (!dig[4]) begin
                r_num_ok <= 1'b0;
            end else if (acc_sat) begin
                r_acc <= hed_pkg::ACC_MAX[20:0];
                r_ovf <= 1'b1;
            end else begin
                r_acc <= acc_sum[20:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_byte <= sel_byte;
            r_run_end  <= i_cmd.run_end;
            r_text_end <= i_cmd.text_end;
        end
    end

    assign o_count     = r_count;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_end   = r_run_end;
    assign o_text_end  = r_text_end;

endmodule

// File: rtl/hed_ctrl.sv
// ============================================================================
// hed_ctrl
// Controller: decides per accepted byte what to emit and sequences the
// replay of a failed reference or a multi-byte UTF-8 sequence.
// ============================================================================
module hed_ctrl #(
    parameter int MAX_REF_CHARS = hed_pkg::MAX_REF_CHARS_DEF,
    localparam int CW = $clog2(MAX_REF_CHARS + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_final,
    input  hed_pkg::t_stat i_stat,
    input  logic [CW-1:0]  i_count,
    output logic           o_in_ready,
    output hed_pkg::t_cmd  o_cmd,
    output logic [CW-1:0]  o_idx
);

    hed_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_len, n_len;
    logic            r_tail_en, n_tail_en;
    logic            r_fin, n_fin;
    logic [2:0]      r_ulen, n_ulen;

    logic          accept;
    logic          d_load;
    hed_pkg::t_src d_src;
    logic          d_last;
    hed_pkg::t_act d_act;
    logic          d_lit;
    logic          d_utf;
    logic [CW-1:0] d_len;
    logic          d_tail;
    logic          chars_last;
    logic          utf_last;

    assign o_in_ready = (r_state == hed_pkg::S_IDLE) && i_stat.out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign chars_last = (r_idx + CW'(1) == r_len);
    assign utf_last   = ({1'b0, r_idx[1:0]} + 3'd1 == r_ulen);

    // What the byte at the input causes, given the collector state.
    always_comb begin
        d_load = 1'b0;
        d_src  = hed_pkg::SRC_IN;
        d_last = 1'b1;
        d_act  = hed_pkg::ACT_NONE;
        d_lit  = 1'b0;
        d_utf  = 1'b0;
        d_len  = i_count;
        d_tail = 1'b0;
        if (!i_stat.collecting) begin
            if (!i_stat.is_amp) begin
                d_load = 1'b1;
            end else if (i_in_final) begin
                d_load = 1'b1;
                d_src  = hed_pkg::SRC_AMP;
                d_act  = hed_pkg::ACT_END;
            end else begin
                d_act = hed_pkg::ACT_START;
            end
        end else if (i_stat.is_semi) begin
            d_act  = hed_pkg::ACT_END;
            d_load = 1'b1;
            if (i_stat.named_ok) begin
                d_src = hed_pkg::SRC_NAMED;
            end else if (i_stat.num_ok) begin
                d_src  = hed_pkg::SRC_UTF;
                d_last = (i_stat.ulen == 3'd1);
                d_utf  = !d_last;
            end else begin
                d_src  = hed_pkg::SRC_AMP;
                d_tail = 1'b1;
                d_last = 1'b0;
                d_lit  = 1'b1;
            end
        end else if (i_stat.is_amp) begin
            d_act  = i_in_final ? hed_pkg::ACT_END : hed_pkg::ACT_START;
            d_load = 1'b1;
            d_src  = hed_pkg::SRC_AMP;
            d_tail = i_in_final;
            d_last = (i_count == '0) && !i_in_final;
            d_lit  = !d_last;
        end else if (!i_stat.full) begin
            if (i_in_final) begin
                d_act  = hed_pkg::ACT_STORE_END;
                d_load = 1'b1;
                d_src  = hed_pkg::SRC_AMP;
                d_len  = i_count + CW'(1);
                d_last = 1'b0;
                d_lit  = 1'b1;
            end else begin
                d_act = hed_pkg::ACT_STORE;
            end
        end else begin
            d_act  = hed_pkg::ACT_END;
            d_load = 1'b1;
            d_src  = hed_pkg::SRC_AMP;
            d_tail = 1'b1;
            d_last = 1'b0;
            d_lit  = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_len     = r_len;
        n_tail_en = r_tail_en;
        n_fin     = r_fin;
        n_ulen    = r_ulen;
        case (r_state)
            hed_pkg::S_IDLE: begin
                if (accept) begin
                    n_fin     = i_in_final;
                    n_len     = d_len;
                    n_tail_en = d_tail;
                    n_ulen    = i_stat.ulen;
                    if (d_utf) begin
                        n_state = hed_pkg::S_UTF;
                        n_idx   = CW'(1);
                    end else if (d_lit) begin
                        n_idx   = '0;
                        n_state = (d_len != '0) ? hed_pkg::S_CHARS : hed_pkg::S_TAIL;
                    end
                end
            end
            hed_pkg::S_CHARS: begin
                if (i_stat.out_free) begin
                    n_idx = r_idx + CW'(1);
                    if (chars_last) begin
                        n_state = r_tail_en ? hed_pkg::S_TAIL : hed_pkg::S_IDLE;
                    end
                end
            end
            hed_pkg::S_TAIL: begin
                if (i_stat.out_free) begin
                    n_state = hed_pkg::S_IDLE;
                end
            end
            hed_pkg::S_UTF: begin
                if (i_stat.out_free) begin
                    n_idx = r_idx + CW'(1);
                    if (utf_last) begin
                        n_state = hed_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = hed_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.accept   = 1'b0;
        o_cmd.act      = hed_pkg::ACT_NONE;
        o_cmd.load     = 1'b0;
        o_cmd.src      = hed_pkg::SRC_IN;
        o_cmd.run_end  = 1'b0;
        o_cmd.text_end = 1'b0;
        o_idx          = r_idx;
        case (r_state)
            hed_pkg::S_IDLE: begin
                o_idx          = '0;
                o_cmd.accept   = accept;
                o_cmd.act      = accept ? d_act : hed_pkg::ACT_NONE;
                o_cmd.load     = accept && d_load;
                o_cmd.src      = d_src;
                o_cmd.run_end  = d_last;
                o_cmd.text_end = d_last && i_in_final;
            end
            hed_pkg::S_CHARS: begin
                o_cmd.load     = i_stat.out_free;
                o_cmd.src      = hed_pkg::SRC_CHAR;
                o_cmd.run_end  = chars_last && !r_tail_en;
                o_cmd.text_end = chars_last && !r_tail_en && r_fin;
            end
            hed_pkg::S_TAIL: begin
                o_cmd.load     = i_stat.out_free;
                o_cmd.src      = hed_pkg::SRC_TAIL;
                o_cmd.run_end  = 1'b1;
                o_cmd.text_end = r_fin;
            end
            hed_pkg::S_UTF: begin
                o_cmd.load     = i_stat.out_free;
                o_cmd.src      = hed_pkg::SRC_UTF;
                o_cmd.run_end  = utf_last;
                o_cmd.text_end = utf_last && r_fin;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hed_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_len     <= n_len;
        r_tail_en <= n_tail_en;
        r_fin     <= n_fin;
        r_ulen    <= n_ulen;
    end

    // The output register is only ever loaded when its byte leaves or it is empty.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_stat.out_free)
        else $error("output register overwritten while full");

    a_chars_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hed_pkg::S_CHARS |-> r_idx < r_len)
        else $error("replay index beyond buffered reference");

    a_utf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hed_pkg::S_UTF |-> ({1'b0, r_idx[1:0]} < r_ulen && r_ulen >= 3'd2))
        else $error("UTF-8 index beyond sequence length");

    a_text_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load && o_cmd.text_end |-> o_cmd.run_end)
        else $error("end of text without end of run");

    a_replay_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hed_pkg::S_TAIL && i_stat.out_free) |=> r_state == hed_pkg::S_IDLE)
        else $error("tail byte did not close the replay");

endmodule

// File: rtl/html_entity_decoder_unit.sv
// ============================================================================
// html_entity_decoder_unit
// Streaming HTML character reference decoder: passes text bytes through and
// replaces named and numeric references by their byte or UTF-8 sequence.
// ============================================================================
//
//  Channel  Dir  tdata            tuser      tlast
//  s_axis   in   [7:0] in_byte    -          in_final
//  m_axis   out  [7:0] out_byte   [0] run_end text_end
//
//  Plain bytes and bytes held in a reference are taken one per cycle while
//  the output register is free; a byte that yields N output bytes holds the
//  input until the replay sequencer has loaded them all, and a failed
//  reference of L held bytes gives '&', those bytes and at most one more.
//  Reset (i_rst_n low, synchronous) empties the output register and leaves
//  the decoder outside any reference. A stall on m_axis holds the input.
//
module html_entity_decoder_unit #(
    parameter int MAX_REF_CHARS = hed_pkg::MAX_REF_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [0:0] m_axis_tuser,   // [0] run_end
    output logic       m_axis_tlast
);

    localparam int CW = $clog2(MAX_REF_CHARS + 1);

    hed_pkg::t_cmd  cmd;
    hed_pkg::t_stat stat;
    logic [CW-1:0]  count;
    logic [CW-1:0]  idx;

    hed_ctrl #(
        .MAX_REF_CHARS(MAX_REF_CHARS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_final (s_axis_tlast),
        .i_stat     (stat),
        .i_count    (count),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    hed_dp #(
        .MAX_REF_CHARS(MAX_REF_CHARS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (s_axis_tdata),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_count     (count),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_run_end   (m_axis_tuser[0]),
        .o_text_end  (m_axis_tlast)
    );

endmodule

// File: tb/sv/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for html_entity_decoder_unit. A byte-level decoder
// model predicts every output transaction, including run_end and text_end.
// Directed tasks cover byte extremes, named and numeric references and
// failing references. A random phase then mixes well-formed references with
// broken ones, under random idling on both streams, after a long output stall.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int          MAX_REF      = hed_pkg::MAX_REF_CHARS_DEF;
    localparam int unsigned CODE_LIMIT   = 'h110000;
    localparam int unsigned ACC_CEIL     = 'h1FFFFF;
    localparam int          RANDOM_BYTES = 300;
    localparam int          SETTLE       = 40;
    localparam int          CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       text_end;
    } t_out_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [0:0] m_axis_tuser;           // [0] run_end
    logic       m_axis_tlast;

    // Decoder model state.
    logic        ref_active = 1'b0;
    logic [7:0]  ref_buf [MAX_REF];
    int unsigned ref_len = 0;

    t_out_beat   decode_buf[$];
    t_out_beat   pending_out[$];
    logic [7:0]  text_q[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  rx_hold_req = 0;
    bit  idle_on = 1'b1;

    string ref_names [6] = '{"amp", "lt", "gt", "quot", "apos", "nbsp"};

    html_entity_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic void emit(input logic [7:0] b);
        decode_buf.push_back('{data: b, run_end: 1'b0, text_end: 1'b0});
    endfunction

    function automatic void emit_literal();
        emit(hed_pkg::CH_AMP);
        for (int i = 0; i < ref_len; i++) begin
            emit(ref_buf[i]);
        end
        ref_active = 1'b0;
        ref_len = 0;
    endfunction

    function automatic bit name_is(input string nm);
        if (ref_len != nm.len()) return 1'b0;
        for (int i = 0; i < nm.len(); i++) begin
            if (ref_buf[i] != nm[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int digit_val(input logic [7:0] c, input bit hex);
        if (c >= "0" && c <= "9") return int'(c) - "0";
        if (hex && c >= "a" && c <= "f") return int'(c) - "a" + 10;
        if (hex && c >= "A" && c <= "F") return int'(c) - "A" + 10;
        return -1;
    endfunction

    // Parses the held bytes as a numeric reference; 1 when it is encodable.
    function automatic bit parse_numeric(output int unsigned cp);
        int unsigned base;
        int unsigned k;
        int unsigned acc;
        bit          ovf;
        int          d;
        cp = 0;
        if (ref_len < 2 || ref_buf[0] != hed_pkg::CH_HASH) return 1'b0;
        base = 10;
        k = 1;
        if (ref_len >= 3 && (ref_buf[1] == hed_pkg::CH_LOW_X
                || ref_buf[1] == hed_pkg::CH_UP_X)) begin
            base = 16;
            k = 2;
        end
        acc = 0;
        ovf = 1'b0;
        while (k < ref_len) begin
            d = digit_val(ref_buf[k], base == 16);
            if (d < 0) return 1'b0;
            acc = acc * base + d;
            if (acc > ACC_CEIL) begin
                acc = ACC_CEIL;
                ovf = 1'b1;
            end
            k++;
        end
        cp = acc;
        return !ovf && acc > 0 && acc < CODE_LIMIT;
    endfunction

    function automatic void emit_utf8(input int unsigned cp);
        if (cp < 'h80) begin
            emit(8'(cp));
        end else if (cp < 'h800) begin
            emit(8'('hC0 | (cp >> 6)));
            emit(8'('h80 | (cp & 'h3F)));
        end else if (cp < 'h10000) begin
            emit(8'('hE0 | (cp >> 12)));
            emit(8'('h80 | ((cp >> 6) & 'h3F)));
            emit(8'('h80 | (cp & 'h3F)));
        end else begin
            emit(8'('hF0 | (cp >> 18)));
            emit(8'('h80 | ((cp >> 12) & 'h3F)));
            emit(8'('h80 | ((cp >> 6) & 'h3F)));
            emit(8'('h80 | (cp & 'h3F)));
        end
    endfunction

    function automatic void close_reference();
        int unsigned cp;
        if (name_is("amp")) emit(hed_pkg::CH_AMP);
        else if (name_is("lt")) emit(hed_pkg::CH_LT);
        else if (name_is("gt")) emit(hed_pkg::CH_GT);
        else if (name_is("quot")) emit(hed_pkg::CH_QUOT);
        else if (name_is("apos")) emit(hed_pkg::CH_APOS);
        else if (name_is("nbsp")) emit(hed_pkg::CH_SPACE);
        else if (parse_numeric(cp)) emit_utf8(cp);
        else begin
            emit_literal();
            emit(hed_pkg::CH_SEMI);
        end
        ref_active = 1'b0;
        ref_len = 0;
    endfunction

    // Predicts the output bytes of one input transaction.
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        t_out_beat last;
        decode_buf.delete();
        if (!ref_active) begin
            if (b == hed_pkg::CH_AMP) begin
                ref_active = 1'b1;
                ref_len = 0;
            end else begin
                emit(b);
            end
        end else if (b == hed_pkg::CH_SEMI) begin
            close_reference();
        end else if (b == hed_pkg::CH_AMP) begin
            emit_literal();
            ref_active = 1'b1;
            ref_len = 0;
        end else if (ref_len < MAX_REF) begin
            ref_buf[ref_len] = b;
            ref_len++;
        end else begin
            emit_literal();
            emit(b);
        end
        if (fin && ref_active) emit_literal();
        if (decode_buf.size() > 0) begin
            last = decode_buf.pop_back();
            last.run_end = 1'b1;
            last.text_end = fin;
            decode_buf.push_back(last);
        end
        foreach (decode_buf[i]) pending_out.push_back(decode_buf[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Stream driving and checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        decode_byte(b, fin);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // Sends the queued bytes; fin_last marks the last one as end of string.
    task automatic send_text(input bit fin_last);
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], fin_last && (i == text_q.size() - 1));
        end
        text_q.delete();
    endtask

    task automatic send_str(input string s, input bit fin_last);
        push_text(s);
        send_text(fin_last);
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic check_out_byte();
        t_out_beat want;
        if (pending_out.size() == 0) begin
            report_mismatch($sformatf("unexpected output byte %02h", m_axis_tdata));
            return;
        end
        want = pending_out.pop_front();
        if (m_axis_tdata !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata, want.data));
        if (m_axis_tuser[0] !== want.run_end)
            report_mismatch($sformatf("run_end %b, want %b on byte %02h",
                                      m_axis_tuser[0], want.run_end, want.data));
        if (m_axis_tlast !== want.text_end)
            report_mismatch($sformatf("text_end %b, want %b on byte %02h",
                                      m_axis_tlast, want.text_end, want.data));
    endtask

    // Output side: a random wait before each transaction, or a long hold
    // when a test asks for one.
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                gap = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                gap = idle_on ? $urandom_range(0, 6) : 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            check_out_byte();
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Random text helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_code_point();
        case ($urandom_range(0, 8))
            0:       return $urandom_range(1, 'h7F);
            1:       return $urandom_range('h80, 'h7FF);
            2:       return $urandom_range('h800, 'hFFFF);
            3:       return $urandom_range('h10000, 'h10FFFF);
            4:       return $urandom_range('hD800, 'hDFFF);
            5:       return 0;
            6:       return $urandom_range('h110000, 'h1FFFFF);
            7:       return $urandom_range('h200000, 'hFFFFFFF);
            default: return $urandom_range(0, 1) ? 'h10FFFF : 1;
        endcase
    endfunction

    function automatic logic [7:0] pick_ref_char();
        string pool;
        pool = "#xX0123456789abcdefABCDEFlmnopqtu";
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic push_named_ref();
        string nm;
        int    pos;
        nm = ref_names[$urandom_range(0, 5)];
        // A flipped letter case must not match.
        if ($urandom_range(0, 7) == 0) begin
            pos = $urandom_range(0, nm.len() - 1);
            nm.putc(pos, nm[pos] ^ 8'h20);
        end
        push_text({"&", nm});
        if ($urandom_range(0, 9) != 0) text_q.push_back(hed_pkg::CH_SEMI);
    endtask

    task automatic push_numeric_ref();
        int unsigned cp;
        bit          hex;
        string       digits;
        cp = pick_code_point();
        hex = $urandom_range(0, 1);
        push_text("&#");
        if (hex) begin
            text_q.push_back($urandom_range(0, 1) ? hed_pkg::CH_LOW_X : hed_pkg::CH_UP_X);
            digits = $sformatf("%0h", cp);
            if ($urandom_range(0, 1)) digits = digits.toupper();
        end else begin
            digits = $sformatf("%0d", cp);
        end
        if ($urandom_range(0, 5) == 0) push_text("0");
        push_text(digits);
        text_q.push_back(hed_pkg::CH_SEMI);
    endtask

    task automatic push_broken_ref();
        text_q.push_back(hed_pkg::CH_AMP);
        repeat ($urandom_range(0, 16)) text_q.push_back(pick_ref_char());
        case ($urandom_range(0, 2))
            0:       text_q.push_back(hed_pkg::CH_SEMI);
            1:       text_q.push_back(hed_pkg::CH_AMP);
            default: ;
        endcase
    endtask

    task automatic push_long_ref();
        text_q.push_back(hed_pkg::CH_AMP);
        repeat ($urandom_range(MAX_REF - 1, MAX_REF + 2)) begin
            text_q.push_back(8'("a" + $urandom_range(0, 25)));
        end
        if ($urandom_range(0, 1)) text_q.push_back(hed_pkg::CH_SEMI);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_plain_bytes();
        text_q = '{8'h00, 8'hFF, 8'h41};
        send_text(1'b1);
    endtask

    task automatic test_named_refs();
        send_str("&amp;&lt;&gt;&quot;&apos;&nbsp;", 1'b1);
    endtask

    task automatic test_numeric_refs();
        send_str("&#x1F600;", 1'b0);
        send_str("&#0;", 1'b0);
        send_str("&#x7FFFFFF;", 1'b1);
    endtask

    task automatic test_failing_refs();
        send_str("&Amp;", 1'b0);
        send_str("&&gt;", 1'b0);
        send_str("&abcdefghijklmnop", 1'b0);
        send_str("&#x4", 1'b1);
    endtask

    // The output stalls for a long stretch while the input keeps offering
    // bytes, so the decoder must hold its input.
    task automatic test_backpressure();
        idle_on = 1'b0;
        rx_hold_req = 300;
        repeat (3) begin
            push_text("&#x10FFFF;&zzzzzz;ab");
        end
        send_text(1'b1);
        idle_on = 1'b1;
        wait_results_done();
    endtask

    task automatic test_random_text();
        int sent;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
                end
                2, 3: push_named_ref();
                4, 5, 6: push_numeric_ref();
                7: push_broken_ref();
                8: push_long_ref();
                default: begin
                    // End of string while a reference is still open.
                    text_q.push_back(hed_pkg::CH_AMP);
                    repeat ($urandom_range(0, 3)) text_q.push_back(pick_ref_char());
                    text_q.push_back(8'("a" + $urandom_range(0, 25)));
                end
            endcase
            sent += text_q.size();
            send_text($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 40) == 0) wait_results_done();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        int waited;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_bytes();
        test_named_refs();
        test_numeric_refs();
        test_failing_refs();
        wait_results_done();
        test_backpressure();
        test_random_text();

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_out.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (pending_out.size() != 0)
            report_mismatch($sformatf("%0d output bytes never arrived", pending_out.size()));
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
